[sv/tmb_pkg.sv]
// ----------------------------------------------------------------------------
// Timer bank package
// Sizes, codes, state encoding and the control and status records that pass
// between the timer bank controller and its row of slot cells.
// ----------------------------------------------------------------------------
package tmb_pkg;

    // Number of timer slots and the most fired beats one tick may produce.
    localparam int TIMER_SLOTS = 16;
    localparam int MAX_RESULTS = 16;

    // Derived widths.
    localparam int SLOT_W   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W    = $clog2(MAX_RESULTS + 1);
    localparam int MODE_W   = 2;
    localparam int HANDLE_W = 4;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;

    // Request kinds carried in the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_TICK = 2'd2
    } t_mode;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_DELETED  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FIRED    = 3'd4,
        ST_NONE     = 3'd5
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DEL,
        S_LOAD,
        S_SCAN,
        S_NONE
    } t_state;

    // Broadcast control from the controller to every cell.
    typedef struct packed {
        logic              add_en;
        logic              load_hit;
        logic              out_free;
        logic              cap_ok;
        logic              one_shot;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] now;
    } t_cell_ctl;

    // Status that each cell reports back to the controller.
    typedef struct packed {
        logic valid;
        logic token;
        logic hit;
        logic hit_above;
        logic take;
    } t_cell_stat;

    // Fits a slot index into the handle field, dropping or adding high bits.
    function automatic logic [HANDLE_W-1:0] to_handle(input logic [SLOT_W-1:0] idx);
        logic [HANDLE_W+SLOT_W-1:0] wide;
        wide = {{HANDLE_W{1'b0}}, idx};
        return wide[HANDLE_W-1:0];
    endfunction

endpackage

[sv/tmb_req_if.sv]
// ----------------------------------------------------------------------------
// Timer bank request channel
// Valid/ready channel carrying one add, delete or tick request per beat.
// ----------------------------------------------------------------------------
interface tmb_req_if;
    logic                          valid;
    logic                          ready;
    logic [tmb_pkg::MODE_W-1:0]    mode;
    logic [tmb_pkg::HANDLE_W-1:0]  handle;
    logic [tmb_pkg::TIME_W-1:0]    period;
    logic                          one_shot;
    logic [tmb_pkg::TIME_W-1:0]    now_time;

    modport source (
        output valid, mode, handle, period, one_shot, now_time,
        input  ready
    );
    modport sink (
        input  valid, mode, handle, period, one_shot, now_time,
        output ready
    );
endinterface

[sv/tmb_res_if.sv]
// ----------------------------------------------------------------------------
// Timer bank result channel
// Valid/ready channel carrying one status beat per result.
// ----------------------------------------------------------------------------
interface tmb_res_if;
    logic                          valid;
    logic                          ready;
    logic [tmb_pkg::STATUS_W-1:0]  status;
    logic [tmb_pkg::HANDLE_W-1:0]  result_handle;
    logic                          last;

    modport source (
        output valid, status, result_handle, last,
        input  ready
    );
    modport sink (
        input  valid, status, result_handle, last,
        output ready
    );
endinterface

[sv/oneshot_periodic_timer_bank.sv]
// ----------------------------------------------------------------------------
// One-shot and periodic timer bank
// Controller and output register around a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   i_req takes one request beat: add (period, one_shot, now_time), delete
//   (handle) or tick (now_time). Mode 3 is taken and dropped without result.
//   o_res gives status beats; last marks the final beat of a request.
//   An add or delete answers in one beat, loaded into the output register
//   once it is free, and the bank returns to idle as the beat is loaded. A
//   tick loads all due flags, then passes a scan token along the row of
//   TIMER_SLOTS cells, one cell per cycle while no fired beat is stalled.
//   Due slots fire in ascending slot order; a tick with no due slot gives
//   one none-fired beat. The length of the cell row sets the tick time; one
//   request is in flight at a time.
//   i_req.ready is high only while no request is in flight.
//   When o_res is stalled the result stays in the output register and the
//   token holds at a cell with a due slot until the beat is taken.
//   Synchronous reset empties all slots and drops any pending beat.
// ----------------------------------------------------------------------------
module oneshot_periodic_timer_bank (
    input  logic i_clk,
    input  logic i_rst_n,
    tmb_req_if.sink   i_req,
    tmb_res_if.source o_res
);
    import tmb_pkg::*;

    t_state r_state, n_state;

    // Captured request.
    logic [HANDLE_W-1:0] r_handle;
    logic [TIME_W-1:0]   r_period;
    logic                r_one_shot;
    logic [TIME_W-1:0]   r_now;

    // Fired beats so far in this tick.
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Output register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [HANDLE_W-1:0] r_res_handle;
    logic                r_last;

    // Cell row.
    t_cell_ctl  ctl;
    t_cell_stat stat    [TIMER_SLOTS];
    logic       tok     [TIMER_SLOTS+1];
    logic       claim   [TIMER_SLOTS+1];
    logic       above   [TIMER_SLOTS+1];
    logic       del_sel [TIMER_SLOTS];

    logic              acc;
    logic              out_free;
    logic              cap_ok;
    logic              del_en;
    logic              found;
    logic              cur_hit;
    logic              cur_above;
    logic              fire;
    logic              res_load;
    t_status           res_status;
    logic [HANDLE_W-1:0] res_handle;
    logic              res_last;
    logic [SLOT_W-1:0] tok_idx;
    logic [SLOT_W-1:0] add_idx;

    assign acc      = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign cap_ok   = r_cnt < CNT_W'(MAX_RESULTS);

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_status;
    assign o_res.result_handle = r_res_handle;
    assign o_res.last          = r_last;

    // Chain ends.
    assign tok[0]            = (r_state == S_LOAD);
    assign claim[0]          = 1'b0;
    assign above[TIMER_SLOTS] = 1'b0;

    // Row of slot cells.
    for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
        assign del_sel[i] = del_en && (int'(r_handle) == i);

        tmb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_del       (del_sel[i]),
            .i_token     (tok[i]),
            .i_claim     (claim[i]),
            .i_hit_above (above[i+1]),
            .o_token     (tok[i+1]),
            .o_claim     (claim[i+1]),
            .o_hit_above (above[i]),
            .o_stat      (stat[i])
        );
    end

    // Summaries of the row: token position, claimed slot, delete target.
    always_comb begin
        tok_idx   = '0;
        add_idx   = '0;
        found     = 1'b0;
        cur_hit   = 1'b0;
        cur_above = 1'b0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (stat[i].token) begin
                tok_idx   = SLOT_W'(i);
                cur_hit   = stat[i].hit;
                cur_above = stat[i].hit_above;
            end
            if (!claim[i] && !stat[i].valid) begin
                add_idx = SLOT_W'(i);
            end
            if ((int'(r_handle) == i) && stat[i].valid) begin
                found = 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (t_mode'(i_req.mode))
                        MODE_ADD:  n_state = S_ADD;
                        MODE_DEL:  n_state = S_DEL;
                        MODE_TICK: n_state = S_LOAD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD, S_DEL, S_NONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: n_state = S_SCAN;
            S_SCAN: begin
                if (tok[TIMER_SLOTS]) begin
                    n_state = (r_cnt == '0 && !fire) ? S_NONE : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the controller: cell control and the next result beat.
    always_comb begin
        ctl = '{add_en: (r_state == S_ADD) && out_free,
                load_hit: (r_state == S_LOAD),
                out_free: out_free,
                cap_ok: cap_ok,
                one_shot: r_one_shot,
                period: r_period,
                now: r_now};
        del_en     = (r_state == S_DEL) && out_free;
        fire       = (r_state == S_SCAN) && cur_hit && cap_ok && out_free;
        res_load   = 1'b0;
        res_status = ST_NONE;
        res_handle = '0;
        res_last   = 1'b1;
        n_cnt      = r_cnt;
        unique case (r_state)
            S_ADD: begin
                res_load = out_free;
                if (claim[TIMER_SLOTS]) begin
                    res_status = ST_ADDED;
                    res_handle = to_handle(add_idx);
                end else begin
                    res_status = ST_FULL;
                end
            end
            S_DEL: begin
                res_load   = out_free;
                res_status = found ? ST_DELETED : ST_NOTFOUND;
                res_handle = r_handle;
            end
            S_LOAD: n_cnt = '0;
            S_SCAN: begin
                res_load   = fire;
                res_status = ST_FIRED;
                res_handle = to_handle(tok_idx);
                res_last   = !cur_above || (r_cnt == CNT_W'(MAX_RESULTS - 1));
                if (fire) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_NONE: res_load = out_free;
            default: res_load = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and result payload.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_handle   <= i_req.handle;
            r_period   <= i_req.period;
            r_one_shot <= i_req.one_shot;
            r_now      <= i_req.now_time;
        end
        if (res_load) begin
            r_status     <= res_status;
            r_res_handle <= res_handle;
            r_last       <= res_last;
        end
    end

`ifndef SYNTHESIS
    logic [TIMER_SLOTS-1:0] tok_vec;
    always_comb begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            tok_vec[i] = stat[i].token;
        end
    end

    // At most one cell holds the scan token.
    a_token_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vec))
        else $error("scan token held by more than one cell");

    // No token outside a tick scan.
    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok_vec != '0) |-> (r_state == S_SCAN))
        else $error("scan token present outside a scan");

    // A fired beat comes from a valid slot.
    a_fire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> stat[tok_idx].valid)
        else $error("fired beat from a free slot");

    // The fired count never passes the per-tick limit.
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("fired count over limit");

    // A captured mode 3 request never leaves idle and loads no beat.
    a_rsvd_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.mode == 2'd3) |=> (r_state == S_IDLE) && !$rose(r_out_valid))
        else $error("reserved request produced work");
`endif

endmodule

[sv/tmb_cell.sv]
// ----------------------------------------------------------------------------
// Timer bank slot cell
// Holds one timer slot. Cells are chained: a free-slot claim ripples up the
// row, pending hits are summarized down the row, and a scan token moves from
// each cell to the next one cycle at a time in a tick unless held on a hit.
// ----------------------------------------------------------------------------
module tmb_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tmb_pkg::t_cell_ctl i_ctl,
    input  logic               i_del,
    input  logic               i_token,
    input  logic               i_claim,
    input  logic               i_hit_above,
    output logic               o_token,
    output logic               o_claim,
    output logic               o_hit_above,
    output tmb_pkg::t_cell_stat o_stat
);
    import tmb_pkg::*;

    logic              r_valid, n_valid;
    logic              r_token, n_token;
    logic              r_hit, n_hit;
    logic              r_one_shot, n_one_shot;
    logic [TIME_W-1:0] r_expiry, n_expiry;
    logic [TIME_W-1:0] r_period, n_period;

    logic take;
    logic fire;
    logic hold;

    // Claim chain picks the lowest free slot; the token stalls on a hit under the
    // fired-beat limit while the output register is busy.
    always_comb begin
        take        = i_ctl.add_en && !i_claim && !r_valid;
        fire        = r_token && r_hit && i_ctl.cap_ok && i_ctl.out_free;
        hold        = r_token && r_hit && i_ctl.cap_ok && !i_ctl.out_free;
        o_claim     = i_claim || !r_valid;
        o_token     = r_token && !hold;
        o_hit_above = r_hit || i_hit_above;
        o_stat      = '{valid: r_valid, token: r_token, hit: r_hit,
                        hit_above: i_hit_above, take: take};
    end

    // Next slot contents.
    always_comb begin
        n_valid    = r_valid;
        n_one_shot = r_one_shot;
        n_expiry   = r_expiry;
        n_period   = r_period;
        n_token    = i_token || (r_token && hold);
        n_hit      = r_hit;
        if (i_ctl.load_hit) begin
            n_hit = r_valid && (r_expiry <= i_ctl.now);
        end else if (fire) begin
            n_hit = 1'b0;
        end
        priority if (take) begin
            n_valid    = 1'b1;
            n_one_shot = i_ctl.one_shot;
            n_period   = i_ctl.period;
            n_expiry   = i_ctl.now + i_ctl.period;
        end else if (i_del) begin
            n_valid = 1'b0;
        end else if (fire) begin
            if (r_one_shot) begin
                n_valid = 1'b0;
            end else begin
                n_expiry = r_expiry + r_period;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_token <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_token <= n_token;
            r_hit   <= n_hit;
        end
    end

    // Slot payload.
    always_ff @(posedge i_clk) begin
        r_one_shot <= n_one_shot;
        r_expiry   <= n_expiry;
        r_period   <= n_period;
    end

endmodule
